### sv/ged_pkg.sv
// shared constants, register codes and a helper for the grayscale erosion / dilation block
// no dependencies
`timescale 1ns / 1ps

package ged_pkg;

	localparam int PIX_W       = 8;
	localparam int FW_W        = 11;
	localparam int FH_W        = 13;
	localparam int MASK_W      = 49;
	localparam int MASK_SIDE   = 7;
	localparam int MASK_REACH  = 3;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 64;
	localparam int HEIGHT_MAX  = 8191;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_RADIUS = 3;

	localparam logic [FW_W-1:0]   FW_RESET   = FW_W'(1024);
	localparam logic [FH_W-1:0]   FH_RESET   = FH_W'(1024);
	localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(64'd2206334976);

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2,
		REG_MASK   = 2'd3
	} reg_idx_t;

	// min for erosion, max for dilation
	function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic dilate);
		logic [PIX_W-1:0] r;
		if (dilate) begin
			r = (b > a) ? b : a;
		end else begin
			r = (b < a) ? b : a;
		end
		return r;
	endfunction

endpackage

### sv/ged_line.sv
// one line store: a row delay memory with registered, write-first read
// depends on ged_pkg
`timescale 1ns / 1ps

module ged_line #(
	parameter int DEPTH = ged_pkg::DEF_MAX_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 rd_en,
	input  logic [$clog2(DEPTH)-1:0]             rd_addr,
	output logic [ged_pkg::PIX_W-1:0]            rd_data,
	input  logic                                 wr_en,
	input  logic [$clog2(DEPTH)-1:0]             wr_addr,
	input  logic [ged_pkg::PIX_W-1:0]            wr_data
);
	import ged_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, forwards a same-cycle write to the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

### sv/ged_cell.sv
// one window cell: holds a pixel and hands it to the next cell on each shift
// depends on ged_pkg
`timescale 1ns / 1ps

module ged_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift_en,
	input  logic [ged_pkg::PIX_W-1:0] din,
	output logic [ged_pkg::PIX_W-1:0] dout
);
	import ged_pkg::*;

	logic [PIX_W-1:0] pix_q;

	// pixel register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift_en) begin
			pix_q <= din;
		end
	end

	assign dout = pix_q;

endmodule

### sv/grayscale_erosion_dilation.sv
// Grayscale erosion / dilation of a raster-order 8-bit pixel stream. Takes one
// word per clock and gives one result per clock unless the master side stalls; a
// result word reaches the master side once the input word that completes its
// window has passed stages 1 to 3 into the output register; frame-wise the output
// lags the input by MAX_RADIUS*width+MAX_RADIUS words, so the caller sends exactly
// that many flush words after each frame. Input is held off after reset and after
// each register write while the derived frame sizes settle. The window holds
// (2*MAX_RADIUS+1)^2 pixel cells fed by 2*MAX_RADIUS line stores of MAX_WIDTH
// entries, each read and written once per word; the min/max is a two-stage
// registered tree (rows, then columns). Line stores are not cleared after reset.
// depends on ged_pkg, ged_line, ged_cell
`timescale 1ns / 1ps

module grayscale_erosion_dilation #(
	parameter int MAX_WIDTH  = ged_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = ged_pkg::DEF_MAX_RADIUS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] pixel_in
	input  logic                          s_tuser,   // [0] flush
	// master stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] pixel_out
	output logic                          m_tlast,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ged_pkg::ADDR_W-1:0]    paddr,
	input  logic [ged_pkg::DATA_W-1:0]    pwdata,
	output logic [ged_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import ged_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int TW = $clog2(HEIGHT_MAX * MAX_WIDTH + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
	localparam int WS = 2 * MAX_RADIUS + 1;
	localparam int NL = 2 * MAX_RADIUS;

	// configuration registers
	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	logic              dilate_q;
	logic [MASK_W-1:0] mask_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= FW_RESET;
			fh_q     <= FH_RESET;
			dilate_q <= 1'b0;
			mask_q   <= MASK_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH:  fw_q     <= pwdata[FW_W-1:0];
				REG_HEIGHT: fh_q     <= pwdata[FH_W-1:0];
				REG_MODE:   dilate_q <= pwdata[0];
				REG_MASK:   mask_q   <= pwdata[MASK_W-1:0];
				default:    fw_q     <= fw_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_WIDTH:  prdata = DATA_W'(fw_q);
			REG_HEIGHT: prdata = DATA_W'(fh_q);
			REG_MODE:   prdata = DATA_W'(dilate_q);
			REG_MASK:   prdata = DATA_W'(mask_q);
			default:    prdata = '0;
		endcase
	end

	// effective geometry
	logic [WW-1:0]   w_eff;
	logic [FH_W-1:0] h_eff;
	logic [TW-1:0]   total_q;
	logic [TW-1:0]   delay_q;
	logic [TW-1:0]   tpd;
	logic            geo_stale_q;

	always_comb begin
		if (fw_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_q);
		end
		h_eff = (fh_q == '0) ? FH_W'(1) : fh_q;
	end

	// frame sizes are registered from the configuration registers, input waits for them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			delay_q     <= '0;
			geo_stale_q <= 1'b1;
		end else begin
			total_q     <= TW'(h_eff) * TW'(w_eff);
			delay_q     <= TW'(MAX_RADIUS) * TW'(w_eff) + TW'(MAX_RADIUS);
			geo_stale_q <= cfg_wr;
		end
	end

	assign tpd = total_q + delay_q;

	// handshake: whole pipeline advances unless the output word is stalled
	logic adv;
	logic in_fire;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv && !geo_stale_q;
	assign in_fire  = s_tvalid && s_tready;

	// stream position counters
	logic [TW-1:0]   pos_q;
	logic [AW-1:0]   col_q;
	logic [AW-1:0]   ox_q;
	logic [FH_W-1:0] oy_q;
	logic            emit;
	logic            drop;
	logic            is_last;
	logic            frame_end;
	logic [PIX_W-1:0] val;

	always_comb begin
		emit      = pos_q >= delay_q;
		drop      = emit && (pos_q >= tpd);
		is_last   = emit && !drop && (pos_q == tpd - TW'(1));
		frame_end = drop || is_last;
		val       = (s_tuser || (pos_q >= total_q)) ? '0 : s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			col_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
		end else if (in_fire) begin
			if (frame_end) begin
				pos_q <= '0;
				col_q <= '0;
				ox_q  <= '0;
				oy_q  <= '0;
			end else begin
				pos_q <= pos_q + TW'(1);
				if ((WW'(col_q) + WW'(1)) >= w_eff) begin
					col_q <= '0;
				end else begin
					col_q <= col_q + AW'(1);
				end
				if (emit) begin
					if ((WW'(ox_q) + WW'(1)) >= w_eff) begin
						ox_q <= '0;
						oy_q <= oy_q + FH_W'(1);
					end else begin
						ox_q <= ox_q + AW'(1);
					end
				end
			end
		end
	end

	// stage 1: accepted word, line store reads in flight
	logic             valid_s1;
	logic [PIX_W-1:0] val_s1;
	logic [AW-1:0]    col_s1;
	logic             emit_s1;
	logic             last_s1;
	logic [AW-1:0]    cx_s1;
	logic [FH_W-1:0]  cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_fire;
			emit_s1  <= in_fire && emit && !drop;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_s1  <= val;
			col_s1  <= col_q;
			last_s1 <= is_last;
			cx_s1   <= ox_q;
			cy_s1   <= oy_q;
		end
	end

	// line stores: store k holds the word k+1 rows back
	logic [PIX_W-1:0] rd [NL];
	logic             shift;

	assign shift = adv && valid_s1;

	for (genvar k = 0; k < NL; k++) begin : g_line
		ged_line #(
			.DEPTH(MAX_WIDTH)
		) u_line (
			.clk     (clk),
			.rd_en   (in_fire),
			.rd_addr (col_q),
			.rd_data (rd[k]),
			.wr_en   (shift),
			.wr_addr (col_s1),
			.wr_data ((k == 0) ? val_s1 : rd[(k == 0) ? 0 : k - 1])
		);
	end

	// window cells: row k is k rows back, column j is j words back
	logic [PIX_W-1:0] win [WS][WS];

	for (genvar k = 0; k < WS; k++) begin : g_row
		for (genvar j = 0; j < WS; j++) begin : g_col
			logic [PIX_W-1:0] din;
			if (j == 0) begin : g_head
				if (k == 0) begin : g_new
					assign din = val_s1;
				end else begin : g_tap
					assign din = rd[k-1];
				end
			end else begin : g_link
				assign din = win[k][j-1];
			end
			ged_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift),
				.din      (din),
				.dout     (win[k][j])
			);
		end
	end

	// stage 2: window holds the neighborhood of the output pixel
	logic             valid_s2;
	logic             last_s2;
	logic [AW-1:0]    cx_s2;
	logic [FH_W-1:0]  cy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			last_s2 <= last_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
		end
	end

	// per-row reduction, masked-out or off-frame cells replaced by the center
	logic [PIX_W-1:0] center;
	logic [PIX_W-1:0] row_red [WS];
	logic [WS-1:0]    col_ok;
	logic [WS-1:0]    row_ok;

	assign center = win[MAX_RADIUS][MAX_RADIUS];

	always_comb begin
		for (int j = 0; j < WS; j++) begin
			col_ok[j] = ((int'(cx_s2) + MAX_RADIUS - j) >= 0) &&
				((int'(cx_s2) + MAX_RADIUS - j) < int'(w_eff));
		end
		for (int k = 0; k < WS; k++) begin
			row_ok[k] = ((int'(cy_s2) + MAX_RADIUS - k) >= 0) &&
				((int'(cy_s2) + MAX_RADIUS - k) < int'(h_eff));
		end
	end

	for (genvar k = 0; k < WS; k++) begin : g_red
		always_comb begin
			logic [PIX_W-1:0] acc;
			acc = center;
			for (int j = 0; j < WS; j++) begin
				if (mask_q[(MASK_REACH + MAX_RADIUS - k) * MASK_SIDE + MASK_REACH + MAX_RADIUS - j]
					&& col_ok[j] && row_ok[k]) begin
					acc = pick(acc, win[k][j], dilate_q);
				end
			end
			row_red[k] = acc;
		end
	end

	// stage 3: row results
	logic             valid_s3;
	logic             last_s3;
	logic [PIX_W-1:0] row_s3 [WS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			last_s3 <= last_s2;
			for (int k = 0; k < WS; k++) begin
				row_s3[k] <= row_red[k];
			end
		end
	end

	// column reduction
	logic [PIX_W-1:0] fin;

	always_comb begin
		fin = row_s3[0];
		for (int k = 1; k < WS; k++) begin
			fin = pick(fin, row_s3[k], dilate_q);
		end
	end

	// output register
	logic             ovalid_q;
	logic [PIX_W-1:0] opix_q;
	logic             olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			opix_q  <= fin;
			olast_q <= last_s3;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = opix_q;
	assign m_tlast  = olast_q;

`ifndef SYNTHESIS
	// frame end returns the position counter to the start
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_end) |=> (pos_q == '0))
		else $error("position not cleared at frame end");

	// a result word in stage 1 reaches stage 2 on the next advance
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && emit_s1) |=> valid_s2)
		else $error("result lost between stage 1 and stage 2");

	// stage 3 always lands in the output register
	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s3) |=> m_tvalid)
		else $error("result lost before output register");

	// a dropped word never produces a result
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && drop) |=> !emit_s1)
		else $error("dropped word marked as result");
`endif

endmodule

### test/tb_grayscale_erosion_dilation.sv
// self-checking testbench for grayscale_erosion_dilation: whole frames plus drain words,
// checked against a behavioral min/max window predictor; depends on ged_pkg and the block
`timescale 1ns / 1ps

module tb_grayscale_erosion_dilation;
	import ged_pkg::*;

	localparam int RADIUS    = DEF_MAX_RADIUS;
	localparam int WIDTH_CAP = DEF_MAX_WIDTH;
	localparam int RING_LEN  = 2 * (RADIUS * WIDTH_CAP + RADIUS) + 1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} result_word_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // [7:0] pixel_in
	logic               s_tuser;   // [0] flush
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // [7:0] pixel_out
	logic               m_tlast;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	// predictor copy of configuration and stream position
	logic [FW_W-1:0]    cfg_width;
	logic [FH_W-1:0]    cfg_height;
	logic               cfg_dilate;
	logic [MASK_W-1:0]  cfg_mask;
	logic [PIX_W-1:0]   pixel_ring [RING_LEN];
	int unsigned        col_pos;
	int unsigned        row_pos;

	result_word_t       pending_pixels [$];
	int                 error_count;
	bit                 calm;
	int                 words_sent;

	grayscale_erosion_dilation DUT (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	// sink backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
		end
	end

	// result checker: ready and valid are stable at the falling edge
	initial begin
		result_word_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_pixels.size() == 0) begin
					$error("unexpected word pixel_out=%0d last=%0b", m_tdata, m_tlast);
					error_count++;
				end else begin
					want = pending_pixels.pop_front();
					if (m_tdata !== want.pixel) begin
						$error("pixel_out expected %0d actual %0d", want.pixel, m_tdata);
						error_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_frame expected %0b actual %0b", want.last, m_tlast);
						error_count++;
					end
				end
			end
		end
	end

	function automatic int unsigned eff_width();
		int unsigned w;
		w = cfg_width;
		if (w == 0) w = 1;
		if (w > WIDTH_CAP) w = WIDTH_CAP;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	// window min/max for one accepted word
	function automatic void predict_window(input logic [7:0] pix, input logic fl);
		int unsigned w, h, lag, total, pos, c, cx, cy;
		int nx, ny, idx;
		logic [PIX_W-1:0] acc, cur;
		result_word_t res;
		w = eff_width();
		h = eff_height();
		lag = RADIUS * w + RADIUS;
		total = h * w;
		pos = row_pos * w + col_pos;
		pixel_ring[pos % RING_LEN] = (fl || pos >= total) ? '0 : pix;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (pos < lag) return;
		c = pos - lag;
		if (c >= total) begin
			col_pos = 0;
			row_pos = 0;
			return;
		end
		cx = c % w;
		cy = c / w;
		acc = pixel_ring[c % RING_LEN];
		for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
			for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
				nx = int'(cx) + dx;
				ny = int'(cy) + dy;
				if (!cfg_mask[(dy + 3) * 7 + (dx + 3)]) continue;
				if (nx < 0 || nx >= int'(w) || ny < 0 || ny >= int'(h)) continue;
				idx = int'(c) + dy * int'(w) + dx;
				cur = pixel_ring[idx % RING_LEN];
				if (cfg_dilate) begin
					if (cur > acc) acc = cur;
				end else begin
					if (cur < acc) acc = cur;
				end
			end
		end
		res.pixel = acc;
		res.last = (c == total - 1);
		if (res.last) begin
			col_pos = 0;
			row_pos = 0;
		end
		pending_pixels.push_back(res);
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH:  cfg_width = value[FW_W-1:0];
			REG_HEIGHT: cfg_height = value[FH_W-1:0];
			REG_MODE:   cfg_dilate = value[0];
			REG_MASK:   cfg_mask = value[MASK_W-1:0];
			default:    ;
		endcase
	endtask

	task automatic configure(input int w, input int h, input bit dil,
		input logic [MASK_W-1:0] msk);
		write_reg(REG_WIDTH, DATA_W'(w));
		write_reg(REG_HEIGHT, DATA_W'(h));
		write_reg(REG_MODE, DATA_W'(dil));
		write_reg(REG_MASK, DATA_W'(msk));
	endtask

	task automatic send_word(input logic [7:0] pix, input logic fl);
		bit rdy;
		while (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tuser <= fl;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		predict_window(pix, fl);
		words_sent++;
	endtask

	// one frame followed by exactly the drain words it needs
	task automatic run_frame(input int flush_pct, input int stray_pct);
		int unsigned w, n;
		w = eff_width();
		n = w * eff_height();
		for (int unsigned i = 0; i < n; i++) begin
			send_word(8'($urandom), $urandom_range(99) < flush_pct);
		end
		for (int unsigned i = 0; i < RADIUS * w + RADIUS; i++)
			send_word(8'($urandom), !($urandom_range(99) < stray_pct));
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [MASK_W-1:0] random_mask();
		return MASK_W'({$urandom, $urandom});
	endfunction

	// extremes of pixels, both modes, empty and full masks, flush in frame
	task automatic test_directed();
		configure(3, 3, 1'b0, '0);
		send_word(8'd0, 1'b0); send_word(8'd255, 1'b0); send_word(8'd17, 1'b1);
		send_word(8'd255, 1'b0); send_word(8'd0, 1'b0); send_word(8'd128, 1'b0);
		send_word(8'd85, 1'b0); send_word(8'd170, 1'b0); send_word(8'd1, 1'b0);
		for (int i = 0; i < 12; i++) send_word(8'hff, i[0]);
		s_tvalid <= 1'b0;
		wait_drained();
		configure(4, 2, 1'b1, '1);
		run_frame(10, 20);
		wait_drained();
		write_reg(REG_MODE, DATA_W'(0));
		write_reg(REG_MASK, DATA_W'(MASK_RESET));
		run_frame(0, 0);
		wait_drained();
	endtask

	// width and height of zero act as one
	task automatic test_zero_geometry();
		configure(0, 0, 1'b1, random_mask());
		run_frame(0, 30);
		wait_drained();
		configure(5, 0, 1'b0, '1);
		run_frame(20, 0);
		wait_drained();
	endtask

	task automatic test_random_frames();
		while (words_sent < 950) begin
			calm = (words_sent > 400 && words_sent < 600);
			configure($urandom_range(1, 12), $urandom_range(1, 8), 1'($urandom_range(1)),
				($urandom_range(9) == 0) ? '1 : random_mask());
			run_frame(4, 4);
			wait_drained();
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		error_count = 0;
		words_sent = 0;
		calm = 1'b0;
		cfg_width = FW_RESET;
		cfg_height = FH_RESET;
		cfg_dilate = 1'b0;
		cfg_mask = MASK_RESET;
		col_pos = 0;
		row_pos = 0;
		foreach (pixel_ring[i]) pixel_ring[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		test_directed();
		test_zero_geometry();
		test_random_frames();
		wait_drained();
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
sv/ged_pkg.sv
sv/ged_line.sv
sv/ged_cell.sv
sv/grayscale_erosion_dilation.sv
test/tb_grayscale_erosion_dilation.sv
